>>> rtl/lfs_pkg.sv
// ----------------------------------------------------------------------------
// lfs_pkg: shared types and constants of the lease failsafe supervisor
// Transaction payload structs, command kinds and the tolerance constants.
// ----------------------------------------------------------------------------
package lfs_pkg;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_ARM  = 2'd1,
		KIND_STOP = 2'd2
	} kind_t;

	localparam int LEASE_W = 31;
	localparam int TIME_W  = 32;
	localparam int OFF_W   = 32;
	localparam int SAFE_W  = 2;

	// Tolerance is max(lease / 10000, 5). The divide is done as a shift by
	// four followed by an exact reciprocal multiply for the divide by 625.
	localparam int TOL_PRE_SHIFT = 4;
	localparam int TOL_ARG_W     = LEASE_W - TOL_PRE_SHIFT;
	localparam int TOL_RECIP_W   = 28;
	localparam logic [TOL_RECIP_W-1:0] TOL_RECIP = 28'd219902326;
	localparam int TOL_SHIFT     = 37;
	localparam int TOL_PROD_W    = TOL_ARG_W + TOL_RECIP_W;
	localparam int TOL_W         = TOL_PROD_W - TOL_SHIFT;
	localparam logic [TOL_W-1:0] TOL_FLOOR = 18'd5;

	localparam logic [LEASE_W-1:0] LEASE_MIN = 31'd1;
	localparam logic [LEASE_W-1:0] LEASE_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [1:0]                kind;
		logic [TIME_W-1:0]         now_ms;
		logic [LEASE_W-1:0]        base_lease_ms;
		logic signed [OFF_W-1:0]   offset_first_ms;
		logic signed [OFF_W-1:0]   offset_second_ms;
		logic [SAFE_W-1:0]         channel_safe;
	} cmd_t;

	typedef struct packed {
		logic                arm_accepted;
		logic                arm_pulse;
		logic                stop_pulse;
		logic [LEASE_W-1:0]  lease_first_ms;
		logic [LEASE_W-1:0]  lease_second_ms;
		logic                expect_safe;
		logic                mismatch_seen;
		logic                latched_fault;
		logic                force_safe;
	} rsp_t;

endpackage

>>> rtl/lease_failsafe_supervisor_core.sv
// ----------------------------------------------------------------------------
// lease_failsafe_supervisor_core: lease failsafe supervisor
// Arms redundant channels on a timed lease and latches a fault on mismatch.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while cmd_ready is high and
// returns exactly one result transaction for each through a single output
// register; cmd_ready stays high while that register is empty or being
// drained, so a steady stream runs at one transaction per cycle. A stop
// transaction pulses stop_pulse, clears the run state and enables arming.
// An arm transaction is honored only after a stop and returns two saturated
// leases (base plus signed offset, clamped to 1 .. 2^31-1). A tick
// transaction, while running, reports whether the lease has elapsed, whether
// any of the CHANNELS lanes disagrees with that expectation (channels beyond
// the two-bit safe field read as not safe), and the fault latch, which is set
// once a mismatch has lasted max(lease / 10000, 5) ms. The tolerance is
// computed by a registered reciprocal multiplier from the armed lease; it
// is first consulted two ticks after that arm, so no stall is ever needed.
// ----------------------------------------------------------------------------
module lease_failsafe_supervisor_core #(
	parameter int CHANNELS = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  lfs_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lfs_pkg::rsp_t  rsp
);

	// Supervisor state.
	logic                           running_q;
	logic                           latched_q;
	logic                           mismatching_q;
	logic                           revoke_seen_q;
	logic [lfs_pkg::LEASE_W-1:0]    lease_length_q;
	logic [lfs_pkg::TIME_W-1:0]     arm_time_q;
	logic [lfs_pkg::TIME_W-1:0]     mismatch_start_q;

	// Output register.
	logic                           rsp_valid_q;
	lfs_pkg::rsp_t                  rsp_q;

	logic                           accept;
	logic [lfs_pkg::TIME_W-1:0]     elapsed;
	logic [lfs_pkg::TIME_W-1:0]     since_mismatch;
	logic [lfs_pkg::TOL_W-1:0]      tol_ms;
	logic                           expect_safe;
	logic                           tol_hit;
	logic                           any_mismatch;
	logic                           latch_now;
	logic [CHANNELS-1:0]            lane_mismatch;
	logic [lfs_pkg::LEASE_W-1:0]    lease_first;
	logic [lfs_pkg::LEASE_W-1:0]    lease_second;
	lfs_pkg::rsp_t                  rsp_next;

	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign accept    = cmd_valid && cmd_ready;

	// Lease elapsed test with wrapping time arithmetic.
	assign elapsed     = cmd.now_ms - arm_time_q;
	assign expect_safe = elapsed >= {1'b0, lease_length_q};

	// One comparison lane per channel; the OR below merges their findings.
	genvar gi;
	generate
		for (gi = 0; gi < CHANNELS; gi++) begin : g_lane
			logic safe_bit;
			if (gi < lfs_pkg::SAFE_W) begin : g_field
				assign safe_bit = cmd.channel_safe[gi];
			end else begin : g_beyond
				assign safe_bit = 1'b0;
			end
			lfs_lane u_lane (
				.channel_safe_bit (safe_bit),
				.expect_safe      (expect_safe),
				.mismatch         (lane_mismatch[gi])
			);
		end
	endgenerate

	assign any_mismatch = |lane_mismatch;

	lfs_tol u_tol (
		.clk          (clk),
		.arst_n       (arst_n),
		.lease_length (lease_length_q),
		.tol_ms       (tol_ms)
	);

	assign since_mismatch = cmd.now_ms - mismatch_start_q;
	assign tol_hit        = since_mismatch >= {{(lfs_pkg::TIME_W-lfs_pkg::TOL_W){1'b0}}, tol_ms};

	// The fault latches on a persisting mismatch once the tolerance is reached.
	assign latch_now = any_mismatch && mismatching_q && !latched_q && tol_hit;

	lfs_lease_sat u_sat_first (
		.base_lease_ms (cmd.base_lease_ms),
		.offset_ms     (cmd.offset_first_ms),
		.lease_ms      (lease_first)
	);

	lfs_lease_sat u_sat_second (
		.base_lease_ms (cmd.base_lease_ms),
		.offset_ms     (cmd.offset_second_ms),
		.lease_ms      (lease_second)
	);

	// Result of the transaction being accepted; fields of other kinds stay zero.
	always_comb begin
		rsp_next = '0;
		case (lfs_pkg::kind_t'(cmd.kind))
			lfs_pkg::KIND_ARM: begin
				if (revoke_seen_q) begin
					rsp_next.arm_accepted    = 1'b1;
					rsp_next.arm_pulse       = 1'b1;
					rsp_next.lease_first_ms  = lease_first;
					rsp_next.lease_second_ms = lease_second;
				end
			end
			lfs_pkg::KIND_STOP: begin
				rsp_next.stop_pulse = 1'b1;
			end
			lfs_pkg::KIND_TICK: begin
				if (running_q) begin
					rsp_next.expect_safe   = expect_safe;
					rsp_next.mismatch_seen = any_mismatch;
					rsp_next.latched_fault = latched_q || latch_now;
					rsp_next.force_safe    = latched_q || latch_now;
				end
			end
			default: begin
				rsp_next = '0;
			end
		endcase
	end

	// State update on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q        <= 1'b0;
			latched_q        <= 1'b0;
			mismatching_q    <= 1'b0;
			revoke_seen_q    <= 1'b0;
			lease_length_q   <= '0;
			arm_time_q       <= '0;
			mismatch_start_q <= '0;
		end else if (accept) begin
			case (lfs_pkg::kind_t'(cmd.kind))
				lfs_pkg::KIND_ARM: begin
					if (revoke_seen_q) begin
						lease_length_q <= cmd.base_lease_ms;
						arm_time_q     <= cmd.now_ms;
						running_q      <= 1'b1;
						latched_q      <= 1'b0;
						mismatching_q  <= 1'b0;
					end
				end
				lfs_pkg::KIND_STOP: begin
					running_q     <= 1'b0;
					latched_q     <= 1'b0;
					mismatching_q <= 1'b0;
					revoke_seen_q <= 1'b1;
				end
				lfs_pkg::KIND_TICK: begin
					if (running_q) begin
						if (any_mismatch) begin
							if (!mismatching_q) begin
								mismatching_q    <= 1'b1;
								mismatch_start_q <= cmd.now_ms;
							end else if (latch_now) begin
								latched_q     <= 1'b1;
								revoke_seen_q <= 1'b0;
							end
						end else begin
							mismatching_q <= 1'b0;
						end
					end
				end
				default: begin
					running_q <= running_q;
				end
			endcase
		end
	end

	// Output register: loads on accept, empties when the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> rtl/lfs_lane.sv
// ----------------------------------------------------------------------------
// lfs_lane: per-channel comparison lane
// Flags a channel whose reported safe state disagrees with the expectation.
// ----------------------------------------------------------------------------
module lfs_lane (
	input  logic channel_safe_bit,
	input  logic expect_safe,
	output logic mismatch
);

	assign mismatch = channel_safe_bit ^ expect_safe;

endmodule

>>> rtl/lfs_lease_sat.sv
// ----------------------------------------------------------------------------
// lfs_lease_sat: saturating lease adder
// Adds a signed offset to the base lease and clamps to 1 .. 2^31-1.
// ----------------------------------------------------------------------------
module lfs_lease_sat (
	input  logic [lfs_pkg::LEASE_W-1:0]      base_lease_ms,
	input  logic signed [lfs_pkg::OFF_W-1:0] offset_ms,
	output logic [lfs_pkg::LEASE_W-1:0]      lease_ms
);

	logic signed [lfs_pkg::OFF_W+1:0] sum;

	assign sum = $signed({3'b000, base_lease_ms})
		+ $signed({{2{offset_ms[lfs_pkg::OFF_W-1]}}, offset_ms});

	always_comb begin
		if (sum[lfs_pkg::OFF_W+1] || (sum == '0)) begin
			lease_ms = lfs_pkg::LEASE_MIN;
		end else if (|sum[lfs_pkg::OFF_W:lfs_pkg::LEASE_W]) begin
			lease_ms = lfs_pkg::LEASE_MAX;
		end else begin
			lease_ms = sum[lfs_pkg::LEASE_W-1:0];
		end
	end

endmodule

>>> rtl/lfs_tol.sv
// ----------------------------------------------------------------------------
// lfs_tol: mismatch tolerance unit
// Registers max(lease / 10000, 5), updating in the cycle after the lease register changes.
// ----------------------------------------------------------------------------
module lfs_tol (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lfs_pkg::LEASE_W-1:0]   lease_length,
	output logic [lfs_pkg::TOL_W-1:0]     tol_ms
);

	logic [lfs_pkg::TOL_PROD_W-1:0] prod;
	logic [lfs_pkg::TOL_W-1:0]      quot;
	logic [lfs_pkg::TOL_W-1:0]      tol_q;

	assign prod = lfs_pkg::TOL_PROD_W'(lease_length[lfs_pkg::LEASE_W-1:lfs_pkg::TOL_PRE_SHIFT])
		* lfs_pkg::TOL_PROD_W'(lfs_pkg::TOL_RECIP);
	assign quot = prod[lfs_pkg::TOL_PROD_W-1:lfs_pkg::TOL_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= lfs_pkg::TOL_FLOOR;
		end else begin
			tol_q <= (quot > lfs_pkg::TOL_FLOOR) ? quot : lfs_pkg::TOL_FLOOR;
		end
	end

	assign tol_ms = tol_q;

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lease_failsafe_supervisor_core
// Drives stop, arm and tick transactions, predicts every result from a
// behavioral copy of the supervisor and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;

	localparam int          CLK_PERIOD     = 12;
	localparam int          NUM_CHANNELS   = 2;
	localparam int          ITEM_TARGET    = 850;
	localparam int          CALM_TAIL      = 120;
	localparam int          HOLD_CYCLES    = 64;
	localparam int          DRAIN_LIMIT    = 2000;
	localparam int          SETTLE_CYCLES  = 8;
	localparam int unsigned TIMEOUT_CYCLES = 400000;
	localparam int unsigned TOL_DIVISOR    = 10000;
	localparam int unsigned TOL_MIN_MS     = 5;
	localparam longint      LEASE_CEIL     = 64'd2147483647;
	localparam logic [1:0]  KIND_UNUSED    = 2'd3;

	// Scoreboard: keeps its own copy of the supervisor state, turns every
	// accepted command into the response it must produce, and checks the
	// responses in order.
	class lease_scoreboard;
		lfs_pkg::rsp_t expected_rsp[$];
		int            errors;
		int            live_ticks;
		int            granted_arms;
		int            stops;
		int            latched_ticks;
		bit            running;
		bit            latched;
		bit            mismatching;
		bit            revoke_seen;
		logic [30:0]   lease_length;
		logic [31:0]   arm_time;
		logic [31:0]   mismatch_start;

		function new();
			errors = 0;
			live_ticks = 0;
			granted_arms = 0;
			stops = 0;
			latched_ticks = 0;
			running = 1'b0;
			latched = 1'b0;
			mismatching = 1'b0;
			revoke_seen = 1'b0;
			lease_length = '0;
			arm_time = '0;
			mismatch_start = '0;
		endfunction

		function logic [30:0] saturate_lease(logic [30:0] base, logic signed [31:0] offset);
			longint sum;
			sum = longint'(base) + longint'(offset);
			if (sum < 1)
				sum = 1;
			if (sum > LEASE_CEIL)
				sum = LEASE_CEIL;
			return sum[30:0];
		endfunction

		function lfs_pkg::rsp_t predict_response(lfs_pkg::cmd_t c);
			lfs_pkg::rsp_t r;
			logic [31:0]   elapsed;
			logic [31:0]   held;
			int unsigned   tol;
			bit            due_safe;
			bit            disagree;
			bit            lane_safe;
			r = '0;
			case (c.kind)
				lfs_pkg::KIND_ARM: begin
					if (revoke_seen) begin
						r.arm_accepted = 1'b1;
						r.arm_pulse = 1'b1;
						r.lease_first_ms = saturate_lease(c.base_lease_ms, c.offset_first_ms);
						r.lease_second_ms = saturate_lease(c.base_lease_ms, c.offset_second_ms);
						lease_length = c.base_lease_ms;
						arm_time = c.now_ms;
						running = 1'b1;
						latched = 1'b0;
						mismatching = 1'b0;
						granted_arms++;
					end
				end
				lfs_pkg::KIND_STOP: begin
					r.stop_pulse = 1'b1;
					running = 1'b0;
					latched = 1'b0;
					mismatching = 1'b0;
					revoke_seen = 1'b1;
					stops++;
				end
				lfs_pkg::KIND_TICK: begin
					if (running) begin
						elapsed = c.now_ms - arm_time;
						due_safe = elapsed >= {1'b0, lease_length};
						disagree = 1'b0;
						// Lanes past the two-bit safe field always read as unsafe.
						for (int i = 0; i < NUM_CHANNELS; i++) begin
							lane_safe = (i < lfs_pkg::SAFE_W) ? c.channel_safe[i] : 1'b0;
							if (lane_safe != due_safe)
								disagree = 1'b1;
						end
						if (disagree) begin
							if (!mismatching) begin
								mismatching = 1'b1;
								mismatch_start = c.now_ms;
							end else if (!latched) begin
								tol = lease_length / TOL_DIVISOR;
								if (tol < TOL_MIN_MS)
									tol = TOL_MIN_MS;
								held = c.now_ms - mismatch_start;
								if (held >= tol) begin
									latched = 1'b1;
									revoke_seen = 1'b0;
								end
							end
						end else begin
							mismatching = 1'b0;
						end
						r.expect_safe = due_safe;
						r.mismatch_seen = disagree;
						r.latched_fault = latched;
						r.force_safe = latched;
						live_ticks++;
						if (latched)
							latched_ticks++;
					end
				end
				default: begin
				end
			endcase
			return r;
		endfunction

		function void note_command(lfs_pkg::cmd_t c);
			expected_rsp.push_back(predict_response(c));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("%s mismatch: expected %h, got %h", name, want, got);
			end
		endfunction

		function void check_response(lfs_pkg::rsp_t got);
			lfs_pkg::rsp_t want;
			if (expected_rsp.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("response %h arrived with nothing outstanding", got);
				return;
			end
			want = expected_rsp.pop_front();
			compare_field("arm_accepted", want.arm_accepted, got.arm_accepted);
			compare_field("arm_pulse", want.arm_pulse, got.arm_pulse);
			compare_field("stop_pulse", want.stop_pulse, got.stop_pulse);
			compare_field("lease_first_ms", want.lease_first_ms, got.lease_first_ms);
			compare_field("lease_second_ms", want.lease_second_ms, got.lease_second_ms);
			compare_field("expect_safe", want.expect_safe, got.expect_safe);
			compare_field("mismatch_seen", want.mismatch_seen, got.mismatch_seen);
			compare_field("latched_fault", want.latched_fault, got.latched_fault);
			compare_field("force_safe", want.force_safe, got.force_safe);
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cmd_valid = 1'b0;
	logic           cmd_ready;
	lfs_pkg::cmd_t  cmd = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	lfs_pkg::rsp_t  rsp;

	// Shared between the stimulus, the response side and the long hold-off.
	logic  hold_off = 1'b0;
	bit    idling_on = 1'b1;
	int    items_sent = 0;

	lease_scoreboard sb = new();

	always #(CLK_PERIOD / 2) clk = ~clk;

	lease_failsafe_supervisor_core #(
		.CHANNELS(NUM_CHANNELS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	function automatic lfs_pkg::cmd_t make_cmd(logic [1:0] kind, logic [31:0] clock_ms,
			logic [30:0] base, logic [31:0] off0, logic [31:0] off1, logic [1:0] safe);
		lfs_pkg::cmd_t c;
		c.kind = kind;
		c.now_ms = clock_ms;
		c.base_lease_ms = base;
		c.offset_first_ms = off0;
		c.offset_second_ms = off1;
		c.channel_safe = safe;
		return c;
	endfunction

	// Offers one command transaction and returns at the edge that accepts it.
	// An optional idle burst comes first; valid then stays high until the
	// handshake completes. Every signal is driven with a nonblocking write at a
	// rising edge and sampled at the edge, so both sides see pre-edge values.
	task automatic send_command(input lfs_pkg::cmd_t c);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		sb.note_command(c);
		if (c.kind != KIND_UNUSED)
			items_sent++;
	endtask

	// Response side: checks every accepted result and throttles rsp_ready in
	// short random bursts, or holds it low while a long hold-off is active.
	initial begin : response_side
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
			if (hold_off) begin
				rsp_ready <= 1'b0;
			end else if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Long hold-offs: the receiver goes quiet while the sender keeps offering,
	// so the output register fills and cmd_ready must drop until the stall is
	// released.
	initial begin : long_hold
		int marks[2];
		marks[0] = 200;
		marks[1] = 520;
		foreach (marks[k]) begin
			wait (items_sent >= marks[k]);
			@(posedge clk);
			hold_off <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		logic [31:0]        clock_ms;
		logic [31:0]        arm_at;
		logic [31:0]        step;
		logic [30:0]        base;
		logic signed [31:0] off0;
		logic signed [31:0] off1;
		logic [1:0]         safe;
		int                 ticks;
		int                 fault_odds;
		int                 drain;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A tick before any arm and an arm before any stop must
		// both come back all zero, and so must the unused kind.
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd0, 31'd0, 32'd0, 32'd0, 2'b11));
		send_command(make_cmd(lfs_pkg::KIND_ARM, 32'd7, 31'd100, 32'd0, 32'd0, 2'b00));
		send_command(make_cmd(KIND_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b11));
		send_command(make_cmd(lfs_pkg::KIND_STOP, 32'd0, 31'd0, 32'd0, 32'd0, 2'b00));
		// Zero base with the most negative offset clamps to the floor of one;
		// with the most positive offset it lands exactly on the ceiling.
		send_command(make_cmd(lfs_pkg::KIND_ARM, 32'hFFFF_FFF0, 31'd0,
			32'h8000_0000, 32'h7FFF_FFFF, 2'b00));
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'hFFFF_FFF0, 31'd0, 32'd0, 32'd0,
			2'b11));
		// A second arm after the same stop restarts the lease. The maximum base
		// plus the largest offset saturates; the tolerance becomes 214748 ms.
		send_command(make_cmd(lfs_pkg::KIND_ARM, 32'hFFFF_FFFE, 31'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 2'b00));
		// The elapsed time wraps through zero and is still well short of the lease.
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd5, 31'd0, 32'd0, 32'd0, 2'b00));
		// The first disagreeing tick only records when the mismatch began.
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd10, 31'd0, 32'd0, 32'd0, 2'b01));
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd214757, 31'd0, 32'd0, 32'd0, 2'b10));
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd214758, 31'd0, 32'd0, 32'd0, 2'b01));
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd214800, 31'd0, 32'd0, 32'd0, 2'b00));
		// Once latched, arming stays locked out until the next stop.
		send_command(make_cmd(lfs_pkg::KIND_ARM, 32'd214900, 31'd100, 32'd0, 32'd0, 2'b00));
		send_command(make_cmd(lfs_pkg::KIND_STOP, 32'd0, 31'd0, 32'd0, 32'd0, 2'b11));
		// A short lease uses the five millisecond tolerance floor.
		send_command(make_cmd(lfs_pkg::KIND_ARM, 32'd1000, 31'd100, 32'd0, 32'd0, 2'b00));
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd1099, 31'd0, 32'd0, 32'd0, 2'b00));
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd1100, 31'd0, 32'd0, 32'd0, 2'b00));
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd1104, 31'd0, 32'd0, 32'd0, 2'b10));
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd1105, 31'd0, 32'd0, 32'd0, 2'b01));
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd1200, 31'd0, 32'd0, 32'd0, 2'b11));
		send_command(make_cmd(lfs_pkg::KIND_STOP, 32'd1300, 31'd0, 32'd0, 32'd0, 2'b00));
		send_command(make_cmd(lfs_pkg::KIND_TICK, 32'd1400, 31'd0, 32'd0, 32'd0, 2'b11));

		// Random part. Most of it is well-formed lease episodes (stop, arm, a
		// run of ticks with a moving clock); the rest is noise of any kind with
		// fully random fields. Idling stops for the last stretch of items.
		while (items_sent < ITEM_TARGET) begin
			idling_on = items_sent < ITEM_TARGET - CALM_TAIL;
			if ($urandom_range(0, 4) == 0) begin
				send_command(make_cmd(2'($urandom_range(0, 3)), $urandom,
					31'($urandom), $urandom, $urandom, 2'($urandom)));
			end else begin
				send_command(make_cmd(lfs_pkg::KIND_STOP, $urandom, 31'($urandom),
					$urandom, $urandom, 2'($urandom)));
				clock_ms = $urandom;
				case ($urandom_range(0, 9))
					0:       base = 31'($urandom);
					1:       base = 31'($urandom_range(49990, 120010));
					default: base = 31'($urandom_range(0, 2500));
				endcase
				if ($urandom_range(0, 4) == 0) begin
					off0 = $urandom;
					off1 = $urandom;
				end else begin
					off0 = int'($urandom_range(0, 400)) - 200;
					off1 = int'($urandom_range(0, 400)) - 200;
				end
				send_command(make_cmd(lfs_pkg::KIND_ARM, clock_ms, base, off0, off1,
					2'($urandom)));
				arm_at = clock_ms;
				// Some episodes run with faulty channels so that latches happen.
				fault_odds = ($urandom_range(0, 2) == 0) ? 60 : 15;
				ticks = $urandom_range(4, 24);
				repeat (ticks) begin
					case ($urandom_range(0, 9))
						0:       step = $urandom;
						1:       step = 32'd0;
						default: step = $urandom_range(1, base / 8 + 2);
					endcase
					clock_ms = clock_ms + step;
					if ($urandom_range(0, 19) == 0) begin
						// Re-arm mid-episode: accepted unless a fault has latched.
						base = 31'($urandom_range(0, 2500));
						send_command(make_cmd(lfs_pkg::KIND_ARM, clock_ms, base, $urandom,
							$urandom, 2'($urandom)));
						arm_at = clock_ms;
					end else begin
						if ($urandom_range(0, 99) < fault_odds)
							safe = 2'($urandom);
						else
							safe = (clock_ms - arm_at >= {1'b0, base}) ? 2'b11 : 2'b00;
						send_command(make_cmd(lfs_pkg::KIND_TICK, clock_ms, 31'($urandom),
							$urandom, $urandom, safe));
					end
				end
			end
		end
		cmd_valid <= 1'b0;

		// Drain: wait for every outstanding response, then let the clock run on to
		// catch anything the block might still emit on its own.
		drain = 0;
		while (sb.expected_rsp.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.expected_rsp.size() != 0) begin
			$display("%0d responses never arrived", sb.expected_rsp.size());
			sb.errors += sb.expected_rsp.size();
		end

		$display("Ran %0d transactions: %0d stops, %0d granted arms, %0d ticks while running.",
			items_sent, sb.stops, sb.granted_arms, sb.live_ticks);
		$display("Fault latch held on %0d ticks; %0d field mismatches counted.",
			sb.latched_ticks, sb.errors);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
